[rtl/assert_macros.svh]
// Assertion macros used by the top level of the stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The condition must hold in every cycle out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

[rtl/bsp_pkg.sv]
// Package with the sizes, codes and helpers of the bounded stack block.
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

   // Stack geometry.
   localparam int unsigned DEPTH   = 8;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

   // Field widths of the request and response items.
   localparam int unsigned TYPE_W   = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 4;

   typedef logic [TYPE_W-1:0]   req_code_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Request codes.
   localparam req_code_type REQ_PUSH  = req_code_type'(0);
   localparam req_code_type REQ_POP   = req_code_type'(1);
   localparam req_code_type REQ_CHECK = req_code_type'(2);

   // Response status codes.
   localparam status_type ST_OK        = status_type'(0);
   localparam status_type ST_OVERFLOW  = status_type'(1);
   localparam status_type ST_UNDERFLOW = status_type'(2);

   // The reported count is the fill level modulo the field range.
   function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] fill);
      logic [CNT_W+COUNT_W-1:0] wide;
      wide = (CNT_W + COUNT_W)'(fill);
      return wide[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/bsp_ram.sv]
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module bsp_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]                           rd_data_a,
   output logic      [WIDTH-1:0]                           rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read ports return the old word on a read during a write.
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

[rtl/bounded_stack_palindrome_check.sv]
// Top level of the bounded stack with push, pop and palindrome check.
//
//   Channel   Handshake            Payload
//   request   start / busy         req_type, req_push_value
//   response  rsp_valid (strobe)   rsp_status, rsp_popped_value, rsp_is_palindrome,
//                                  rsp_count, rsp_full_res, rsp_empty_res
//
// A push, a refused request, an unused request code and a check of a single entry
// give their response in the cycle after the item is taken. A pop issues a RAM read,
// then registers the response with the popped word. A check walks pairs from the
// outside in and ends early at the first pair that differs; the shared comparator
// looks at one pair of entries per cycle through the two RAM read ports.
// Reset clears the fill count, the sequencer and the response strobe; RAM contents
// are left as they are. Busy is high while a pop or a check is in flight, and the
// response strobe is never held off.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounded_stack_palindrome_check (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [bsp_pkg::TYPE_W-1:0]          req_type,
   input  wire logic signed [bsp_pkg::WORD_W-1:0]   req_push_value,
   output logic                                     rsp_valid,
   output logic      [bsp_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [bsp_pkg::WORD_W-1:0]        rsp_popped_value,
   output logic                                     rsp_is_palindrome,
   output logic      [bsp_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                     rsp_full_res,
   output logic                                     rsp_empty_res
);

   // Sequencer state codes.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_POP   = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [bsp_pkg::CNT_W-1:0]        fill_ff, fill_in;
   logic [bsp_pkg::ADDR_W-1:0]       lo_ff, lo_in;
   logic [bsp_pkg::ADDR_W-1:0]       hi_ff, hi_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bsp_pkg::status_type              status_ff, status_in;
   logic [bsp_pkg::WORD_W-1:0]       popped_ff, popped_in;
   logic                             pal_ff, pal_in;
   logic [bsp_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             full_ff, full_in;
   logic                             empty_ff, empty_in;

   logic                             accept;
   logic                             is_full;
   logic                             is_empty;
   logic [bsp_pkg::ADDR_W-1:0]       top_addr;
   logic [bsp_pkg::ADDR_W:0]         lo_step;
   logic [bsp_pkg::ADDR_W:0]         hi_step;
   logic                             wr_en;
   logic [bsp_pkg::WORD_W-1:0]       rd_lo;
   logic [bsp_pkg::WORD_W-1:0]       rd_hi;

   // Entry storage; reads are issued with the next pair of addresses.
   bsp_ram #(
      .WIDTH (bsp_pkg::WORD_W),
      .DEPTH (bsp_pkg::DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (bsp_pkg::ADDR_W'(fill_ff)),
      .wr_data   (req_push_value),
      .rd_addr_a (lo_in),
      .rd_addr_b (hi_in),
      .rd_data_a (rd_lo),
      .rd_data_b (rd_hi)
   );

   // Stack status and pointer arithmetic.
   assign accept   = start && (state_ff == S_IDLE);
   assign is_full  = (fill_ff == bsp_pkg::CNT_W'(bsp_pkg::DEPTH));
   assign is_empty = (fill_ff == '0);
   assign top_addr = bsp_pkg::ADDR_W'(fill_ff - bsp_pkg::CNT_W'(1));
   assign lo_step  = {1'b0, lo_ff} + (bsp_pkg::ADDR_W + 1)'(1);
   assign hi_step  = {1'b0, hi_ff} - (bsp_pkg::ADDR_W + 1)'(1);

   // Sequencer: decodes an item, then finishes a pop or walks pairs with the shared comparator.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      wr_en        = 1'b0;
      rsp_valid_in = 1'b0;
      status_in    = bsp_pkg::ST_OK;
      popped_in    = '0;
      pal_in       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  bsp_pkg::REQ_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        status_in = bsp_pkg::ST_OVERFLOW;
                     end else begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + bsp_pkg::CNT_W'(1);
                     end
                  end
                  bsp_pkg::REQ_POP: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        status_in    = bsp_pkg::ST_UNDERFLOW;
                     end else begin
                        hi_in    = top_addr;
                        state_in = S_POP;
                     end
                  end
                  bsp_pkg::REQ_CHECK: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        status_in    = bsp_pkg::ST_UNDERFLOW;
                     end else begin
                        lo_in = '0;
                        hi_in = top_addr;
                        if (top_addr == '0) begin
                           // A single entry reads the same both ways.
                           rsp_valid_in = 1'b1;
                           pal_in       = 1'b1;
                        end else begin
                           state_in = S_CHECK;
                        end
                     end
                  end
                  default: begin
                     // An unused request code changes nothing.
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            fill_in      = fill_ff - bsp_pkg::CNT_W'(1);
            popped_in    = rd_hi;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_CHECK: begin
            if (rd_lo != rd_hi) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (lo_step < hi_step) begin
               lo_in = lo_step[bsp_pkg::ADDR_W-1:0];
               hi_in = hi_step[bsp_pkg::ADDR_W-1:0];
            end else begin
               rsp_valid_in = 1'b1;
               pal_in       = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      count_in = bsp_pkg::count_field(fill_in);
      full_in  = (fill_in == bsp_pkg::CNT_W'(bsp_pkg::DEPTH));
      empty_in = (fill_in == '0);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pair pointers and response payload.
   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (rsp_valid_in) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
         pal_ff    <= pal_in;
         count_ff  <= count_in;
         full_ff   <= full_in;
         empty_ff  <= empty_in;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_popped_value  = popped_ff;
   assign rsp_is_palindrome = pal_ff;
   assign rsp_count         = count_ff;
   assign rsp_full_res      = full_ff;
   assign rsp_empty_res     = empty_ff;

   // Checks on the sequencer and the fill level.
   `ASSERT_SAME(a_rsp_not_busy, clock, reset, rsp_valid_ff, state_ff == S_IDLE, "response while busy")
   `ASSERT_NEXT(a_push_one_cycle, clock, reset, accept && (req_type == bsp_pkg::REQ_PUSH), rsp_valid_ff, "push response late")
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= bsp_pkg::CNT_W'(bsp_pkg::DEPTH), "fill level above depth")
   `ASSERT_SAME(a_pair_order, clock, reset, state_ff == S_CHECK, lo_ff < hi_ff, "pair pointers crossed")

endmodule

`default_nettype wire
